[src/pdu_pkg.sv]
// shared constants, types and helper functions of the periodic displacement unit
package pdu_pkg;

	localparam int ACC_W = 130;
	localparam int RED_FRAC = 28;
	localparam int TABLE_DEPTH = 42;
	localparam int DEF_MAX_WRAP_STEPS = 8;
	localparam int DEF_POS_FRAC_BITS = 16;

	localparam logic [5:0] IDX_CUR_INV = 6'd0;
	localparam logic [5:0] IDX_REF_INV = 6'd12;
	localparam logic [5:0] IDX_CUR_CELL = 6'd24;
	localparam logic [5:0] IDX_REF_CELL = 6'd33;

	localparam logic [1:0] MODE_DIRECT = 2'd0;
	localparam logic [1:0] MODE_REF_CELL = 2'd1;

	localparam logic signed [ACC_W-1:0] RED_MAX = {{(ACC_W-62){1'b0}}, {62{1'b1}}};
	localparam logic signed [ACC_W-1:0] RED_MIN = {{(ACC_W-62){1'b1}}, {62{1'b0}}};
	localparam logic signed [ACC_W-1:0] S32_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] S32_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
	localparam logic [63:0] RED_HALF = 64'd1 << (RED_FRAC - 1);

	typedef enum logic [1:0] {
		REG_MODE,
		REG_WRAP,
		REG_MASK
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       wrap_en;
		logic [2:0] pmask;
	} cfg_t;

	typedef struct packed {
		logic             ld;
		logic             start;
		logic [ACC_W-1:0] ld_val;
		logic [63:0]      a;
		logic [63:0]      b;
	} mac_cmd_t;

	function automatic logic [63:0] sat62(input logic signed [ACC_W-1:0] v);
		logic [63:0] r;
		if (v > RED_MAX) r = RED_MAX[63:0];
		else if (v < RED_MIN) r = RED_MIN[63:0];
		else r = v[63:0];
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [31:0] r;
		if (v > S32_MAX) r = S32_MAX[31:0];
		else if (v < S32_MIN) r = S32_MIN[31:0];
		else r = v[31:0];
		return r;
	endfunction

	// wrap a reduced difference into [-0.5, 0.5)
	function automatic logic [63:0] wrap_red(input logic [63:0] d);
		logic [RED_FRAC-1:0] w;
		w = d[RED_FRAC-1:0] + RED_HALF[RED_FRAC-1:0];
		return {{(64-RED_FRAC){1'b0}}, w} - RED_HALF;
	endfunction

endpackage

[src/pdu_cfg.sv]
// configuration register file with apb-style access
module pdu_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output pdu_pkg::cfg_t      cfg
);

	pdu_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= 2'd0;
			cfg_q.wrap_en <= 1'b1;
			cfg_q.pmask <= 3'd7;
		end else if (wr_en) begin
			unique case (pdu_pkg::reg_idx_t'(paddr[3:2]))
				pdu_pkg::REG_MODE: cfg_q.mode <= pwdata[1:0];
				pdu_pkg::REG_WRAP: cfg_q.wrap_en <= pwdata[0];
				pdu_pkg::REG_MASK: cfg_q.pmask <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (pdu_pkg::reg_idx_t'(paddr[3:2]))
			pdu_pkg::REG_MODE: prdata = {30'd0, cfg_q.mode};
			pdu_pkg::REG_WRAP: prdata = {31'd0, cfg_q.wrap_en};
			pdu_pkg::REG_MASK: prdata = {29'd0, cfg_q.pmask};
			default: prdata = 32'd0;
		endcase
	end

endmodule

[src/pdu_mac.sv]
// shared 64x64 signed multiply-accumulate built on one 32x32 multiplier
module pdu_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pdu_pkg::mac_cmd_t           cmd,
	output logic                        busy,
	output logic [pdu_pkg::ACC_W-1:0]   acc
);

	localparam int AW = pdu_pkg::ACC_W;

	logic [63:0]   am_q, bm_q;
	logic          neg_q;
	logic [1:0]    cnt_q;
	logic          run_q;
	logic [63:0]   pp_s1;
	logic [1:0]    sh_s1;
	logic          neg_s1;
	logic          vld_s1;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] pp_ext;

	assign busy = run_q | vld_s1;
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			vld_s1 <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			vld_s1 <= run_q;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= 2'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			am_q <= cmd.a[63] ? 64'd0 - cmd.a : cmd.a;
			bm_q <= cmd.b[63] ? 64'd0 - cmd.b : cmd.b;
			neg_q <= cmd.a[63] ^ cmd.b[63];
		end
		pp_s1 <= am_q[{cnt_q[0], 5'd0} +: 32] * bm_q[{cnt_q[1], 5'd0} +: 32];
		sh_s1 <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
		neg_s1 <= neg_q;
		if (cmd.ld) acc_q <= cmd.ld_val;
		else if (vld_s1) acc_q <= neg_s1 ? acc_q - pp_ext : acc_q + pp_ext;
	end

	always_comb begin
		case (sh_s1)
			2'd0: pp_ext = AW'(pp_s1);
			2'd1: pp_ext = AW'(pp_s1) << 32;
			2'd2: pp_ext = AW'(pp_s1) << 64;
			default: pp_ext = '0;
		endcase
	end

endmodule

[src/pdu_isqrt.sv]
// iterative integer square root, two radicand bits per cycle
module pdu_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        busy,
	output logic [31:0] root
);

	logic [63:0] x_q, r_q, bit_q, trial;
	logic        busy_q;

	assign busy = busy_q;
	assign root = r_q[31:0];
	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			r_q <= 64'd0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

[src/pdu_core.sv]
// sequencer, coefficient memory and working registers of the displacement unit
module pdu_core #(
	parameter int MAX_WRAP_STEPS = pdu_pkg::DEF_MAX_WRAP_STEPS,
	parameter int POS_FRAC_BITS = pdu_pkg::DEF_POS_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdu_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [5:0]          coef_index,
	input  logic signed [47:0]  coef_value,
	input  logic signed [31:0]  cur_x,
	input  logic signed [31:0]  cur_y,
	input  logic signed [31:0]  cur_z,
	input  logic signed [31:0]  ref_x,
	input  logic signed [31:0]  ref_y,
	input  logic signed [31:0]  ref_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  disp_x,
	output logic signed [31:0]  disp_y,
	output logic signed [31:0]  disp_z,
	output logic [31:0]         magnitude,
	output logic                wrap_limit_hit
);

	localparam int AW = pdu_pkg::ACC_W;
	localparam int RED_SH = POS_FRAC_BITS + 32 - pdu_pkg::RED_FRAC;
	localparam int MAP_SH = 32 + pdu_pkg::RED_FRAC - POS_FRAC_BITS;
	localparam int DIR_SH = 32 - POS_FRAC_BITS;
	localparam int SW = $clog2(MAX_WRAP_STEPS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_R_FT, S_R_LD, S_R_FC, S_R_MAC, S_R_WT, S_R_SV,
		S_M_INIT, S_M_FC, S_M_MAC, S_M_WT, S_M_SV,
		S_D_AXIS, S_D_CF, S_D_CW, S_D_CMP, S_D_RND,
		S_SQ_CLR, S_SQ_MAC, S_SQ_WT, S_SQRT, S_SQRT_WT, S_DONE
	} state_t;

	typedef enum logic [1:0] {SRC_U, SRC_T, SRC_D} src_t;

	state_t            state_q;
	src_t              src_q;
	logic              m_q, neg_q, flag_q, out_valid_q;
	logic [1:0]        r_q, c_q, k_q;
	logic [SW-1:0]     s_q;
	logic [31:0]       cur_q [3];
	logic [31:0]       ref_q [3];
	logic [63:0]       red_q [3];
	logic [63:0]       u_q [3];
	logic [47:0]       col_q [3];
	logic [31:0]       d_q [3];
	logic [AW-1:0]     squ_q;
	logic [31:0]       dx_q, dy_q, dz_q, mag_q;
	logic              hit_q;

	logic [47:0]       coef_mem [pdu_pkg::TABLE_DEPTH];
	logic [47:0]       rdata_q;
	logic [5:0]        raddr, base, cell_base;

	pdu_pkg::mac_cmd_t mac_cmd;
	logic              mac_busy;
	logic [AW-1:0]     mac_acc;
	logic signed [AW-1:0] acc_s;
	logic [63:0]       red_val, red_diff;
	logic [31:0]       map_val;
	logic [63:0]       t_vec [3];
	logic [31:0]       rnd_val [3];
	logic signed [AW-1:0] rnd_in [3];
	logic [63:0]       sqv, pos64;
	logic [31:0]       in_cur [3];
	logic [31:0]       in_ref [3];
	logic [32:0]       diff [3];
	logic              sq_start, sq_busy;
	logic [31:0]       sq_root;
	logic              accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign disp_x = dx_q;
	assign disp_y = dy_q;
	assign disp_z = dz_q;
	assign magnitude = mag_q;
	assign wrap_limit_hit = hit_q;

	assign in_cur[0] = cur_x;
	assign in_cur[1] = cur_y;
	assign in_cur[2] = cur_z;
	assign in_ref[0] = ref_x;
	assign in_ref[1] = ref_y;
	assign in_ref[2] = ref_z;

	assign acc_s = mac_acc;
	assign base = m_q ? pdu_pkg::IDX_REF_INV : pdu_pkg::IDX_CUR_INV;
	assign cell_base = (cfg.mode == pdu_pkg::MODE_REF_CELL) ? pdu_pkg::IDX_REF_CELL
		: pdu_pkg::IDX_CUR_CELL;
	assign red_val = pdu_pkg::sat62(acc_s >>> RED_SH);
	assign red_diff = red_q[r_q] - red_val;
	assign map_val = pdu_pkg::sat32(acc_s >>> MAP_SH);
	assign pos64 = m_q ? {{32{ref_q[c_q][31]}}, ref_q[c_q]} : {{32{cur_q[c_q][31]}}, cur_q[c_q]};
	assign sq_start = (state_q == S_SQRT);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_vec[i] = neg_q ? u_q[i] - {{16{col_q[i][47]}}, col_q[i]}
				: u_q[i] + {{16{col_q[i][47]}}, col_q[i]};
			rnd_in[i] = {{(AW-64){u_q[i][63]}}, u_q[i]} + (AW'(1) << (DIR_SH - 1));
			rnd_val[i] = pdu_pkg::sat32(rnd_in[i] >>> DIR_SH);
			diff[i] = {in_cur[i][31], in_cur[i]} - {in_ref[i][31], in_ref[i]};
		end
	end

	always_comb begin
		case (src_q)
			SRC_U: sqv = u_q[c_q];
			SRC_T: sqv = t_vec[c_q];
			default: sqv = {{32{d_q[c_q][31]}}, d_q[c_q]};
		endcase
	end

	always_comb begin
		raddr = 6'd0;
		unique case (state_q)
			S_R_FT: raddr = base + {2'b00, r_q, 2'b00} + 6'd3;
			S_R_FC: raddr = base + {2'b00, r_q, 2'b00} + {4'd0, c_q};
			S_M_FC: raddr = cell_base + {3'd0, r_q, 1'b0} + {4'd0, r_q} + {4'd0, c_q};
			S_D_CF: raddr = pdu_pkg::IDX_REF_CELL + {3'd0, r_q, 1'b0} + {4'd0, r_q}
				+ {4'd0, k_q};
			default: raddr = 6'd0;
		endcase
	end

	always_comb begin
		mac_cmd.ld = 1'b0;
		mac_cmd.start = 1'b0;
		mac_cmd.ld_val = '0;
		mac_cmd.a = 64'd0;
		mac_cmd.b = 64'd0;
		unique case (state_q)
			S_R_LD: begin
				mac_cmd.ld = 1'b1;
				mac_cmd.ld_val = {{(AW-48){rdata_q[47]}}, rdata_q} << POS_FRAC_BITS;
			end
			S_R_MAC: begin
				mac_cmd.start = 1'b1;
				mac_cmd.a = pos64;
				mac_cmd.b = {{16{rdata_q[47]}}, rdata_q};
			end
			S_M_INIT: begin
				mac_cmd.ld = 1'b1;
				mac_cmd.ld_val = AW'(1) << (MAP_SH - 1);
			end
			S_M_MAC: begin
				mac_cmd.start = 1'b1;
				mac_cmd.a = red_q[c_q];
				mac_cmd.b = {{16{rdata_q[47]}}, rdata_q};
			end
			S_SQ_CLR: mac_cmd.ld = 1'b1;
			S_SQ_MAC: begin
				mac_cmd.start = 1'b1;
				mac_cmd.a = sqv;
				mac_cmd.b = sqv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && !func && coef_index < 6'(pdu_pkg::TABLE_DEPTH))
			coef_mem[coef_index] <= coef_value;
		rdata_q <= coef_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			src_q <= SRC_U;
			m_q <= 1'b0;
			neg_q <= 1'b0;
			flag_q <= 1'b0;
			r_q <= 2'd0;
			c_q <= 2'd0;
			k_q <= 2'd0;
			s_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && func) begin
						flag_q <= 1'b0;
						m_q <= 1'b0;
						r_q <= 2'd0;
						c_q <= 2'd0;
						k_q <= 2'd0;
						for (int i = 0; i < 3; i++) begin
							cur_q[i] <= in_cur[i];
							ref_q[i] <= in_ref[i];
							u_q[i] <= {{31{diff[i][32]}}, diff[i]} << DIR_SH;
						end
						if (cfg.mode != pdu_pkg::MODE_DIRECT) begin
							state_q <= S_R_FT;
						end else if (cfg.wrap_en) begin
							src_q <= SRC_U;
							state_q <= S_SQ_CLR;
						end else begin
							state_q <= S_D_RND;
						end
					end
				end
				S_R_FT: state_q <= S_R_LD;
				S_R_LD: begin
					c_q <= 2'd0;
					state_q <= S_R_FC;
				end
				S_R_FC: state_q <= S_R_MAC;
				S_R_MAC: state_q <= S_R_WT;
				S_R_WT: begin
					if (!mac_busy) begin
						if (c_q == 2'd2) begin
							state_q <= S_R_SV;
						end else begin
							c_q <= c_q + 2'd1;
							state_q <= S_R_FC;
						end
					end
				end
				S_R_SV: begin
					if (!m_q) red_q[r_q] <= red_val;
					else if (cfg.wrap_en && cfg.pmask[r_q]) red_q[r_q] <= pdu_pkg::wrap_red(red_diff);
					else red_q[r_q] <= red_diff;
					if (r_q == 2'd2) begin
						r_q <= 2'd0;
						if (!m_q) begin
							m_q <= 1'b1;
							state_q <= S_R_FT;
						end else begin
							state_q <= S_M_INIT;
						end
					end else begin
						r_q <= r_q + 2'd1;
						state_q <= S_R_FT;
					end
				end
				S_M_INIT: begin
					c_q <= 2'd0;
					state_q <= S_M_FC;
				end
				S_M_FC: state_q <= S_M_MAC;
				S_M_MAC: state_q <= S_M_WT;
				S_M_WT: begin
					if (!mac_busy) begin
						if (c_q == 2'd2) begin
							state_q <= S_M_SV;
						end else begin
							c_q <= c_q + 2'd1;
							state_q <= S_M_FC;
						end
					end
				end
				S_M_SV: begin
					d_q[r_q] <= map_val;
					if (r_q == 2'd2) begin
						src_q <= SRC_D;
						state_q <= S_SQ_CLR;
					end else begin
						r_q <= r_q + 2'd1;
						state_q <= S_M_INIT;
					end
				end
				S_D_AXIS: begin
					if (k_q == 2'd3) begin
						state_q <= S_D_RND;
					end else if (!cfg.pmask[k_q]) begin
						k_q <= k_q + 2'd1;
					end else begin
						r_q <= 2'd0;
						state_q <= S_D_CF;
					end
				end
				S_D_CF: state_q <= S_D_CW;
				S_D_CW: begin
					col_q[r_q] <= rdata_q;
					if (r_q == 2'd2) begin
						neg_q <= 1'b0;
						s_q <= '0;
						src_q <= SRC_T;
						state_q <= S_SQ_CLR;
					end else begin
						r_q <= r_q + 2'd1;
						state_q <= S_D_CF;
					end
				end
				S_D_CMP: begin
					if ($signed(mac_acc) < $signed(squ_q) && s_q != SW'(MAX_WRAP_STEPS)) begin
						for (int i = 0; i < 3; i++) u_q[i] <= t_vec[i];
						squ_q <= mac_acc;
						s_q <= s_q + 1'b1;
						state_q <= S_SQ_CLR;
					end else begin
						if ($signed(mac_acc) < $signed(squ_q)) flag_q <= 1'b1;
						if (!neg_q) begin
							neg_q <= 1'b1;
							s_q <= '0;
							state_q <= S_SQ_CLR;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= S_D_AXIS;
						end
					end
				end
				S_D_RND: begin
					for (int i = 0; i < 3; i++) d_q[i] <= rnd_val[i];
					src_q <= SRC_D;
					state_q <= S_SQ_CLR;
				end
				S_SQ_CLR: begin
					c_q <= 2'd0;
					state_q <= S_SQ_MAC;
				end
				S_SQ_MAC: state_q <= S_SQ_WT;
				S_SQ_WT: begin
					if (!mac_busy) begin
						if (c_q == 2'd2) begin
							case (src_q)
								SRC_U: begin
									squ_q <= mac_acc;
									state_q <= S_D_AXIS;
								end
								SRC_T: state_q <= S_D_CMP;
								default: state_q <= S_SQRT;
							endcase
						end else begin
							c_q <= c_q + 2'd1;
							state_q <= S_SQ_MAC;
						end
					end
				end
				S_SQRT: state_q <= S_SQRT_WT;
				S_SQRT_WT: if (!sq_busy) state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						dx_q <= d_q[0];
						dy_q <= d_q[1];
						dz_q <= d_q[2];
						mag_q <= sq_root;
						hit_q <= flag_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	pdu_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	pdu_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (mac_acc[63:0]),
		.busy   (sq_busy),
		.root   (sq_root)
	);

endmodule

[src/periodic_displacement_unit.sv]
// top level of the periodic displacement unit
// A load item (func 0) writes one coefficient when its index is below the
// table depth. A compute item runs through one 32x32 multiplier that forms
// each product from four partial products, then through a square root; in
// direct mode with wrapping on, each periodic axis adds column trials. The
// block takes no new item while a compute item is in progress, but accepts
// one while the previous result waits at the output register.
module periodic_displacement_unit #(
	parameter int MAX_WRAP_STEPS = pdu_pkg::DEF_MAX_WRAP_STEPS,
	parameter int POS_FRAC_BITS = pdu_pkg::DEF_POS_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic [5:0]          coef_index,
	input  logic signed [47:0]  coef_value,
	input  logic signed [31:0]  cur_x,
	input  logic signed [31:0]  cur_y,
	input  logic signed [31:0]  cur_z,
	input  logic signed [31:0]  ref_x,
	input  logic signed [31:0]  ref_y,
	input  logic signed [31:0]  ref_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  disp_x,
	output logic signed [31:0]  disp_y,
	output logic signed [31:0]  disp_z,
	output logic [31:0]         magnitude,
	output logic                wrap_limit_hit
);

	pdu_pkg::cfg_t cfg;

	pdu_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdu_core #(
		.MAX_WRAP_STEPS (MAX_WRAP_STEPS),
		.POS_FRAC_BITS  (POS_FRAC_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.coef_index     (coef_index),
		.coef_value     (coef_value),
		.cur_x          (cur_x),
		.cur_y          (cur_y),
		.cur_z          (cur_z),
		.ref_x          (ref_x),
		.ref_y          (ref_y),
		.ref_z          (ref_z),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.disp_x         (disp_x),
		.disp_y         (disp_y),
		.disp_z         (disp_z),
		.magnitude      (magnitude),
		.wrap_limit_hit (wrap_limit_hit)
	);

endmodule
